// File: rtl/ptq_pkg.sv
// Package for the priority task queue: word types, codes and sizing constants.
// Used by every module in the rtl folder; depends on nothing.
`timescale 1ns / 1ps
package ptq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int PRIO_LEVELS_DEF = 4;
  localparam int ID_BITS_DEF = 16;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    FN_ADD = 3'd0,
    FN_CANCEL = 3'd1,
    FN_TAKE = 3'd2,
    FN_FINISH = 3'd3,
    FN_CLEAR = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_FULL = 3'd1,
    ST_EMPTY = 3'd2,
    ST_PAUSED = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_DROPPED = 3'd5,
    ST_BAD = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0] func;
    logic [1:0] priority_req;
    logic [31:0] routine;
    logic [31:0] argument;
    logic [15:0] task_id;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [15:0] result_id;
    logic [31:0] out_routine;
    logic [31:0] out_argument;
    logic [4:0] pending;
    logic [15:0] active;
    logic [15:0] completed;
  } out_word_t;

endpackage

// File: rtl/priority_task_queue_top.sv
// Top level of the priority task queue: a sequencer that walks one entry memory.
// Depends on ptq_pkg.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  ptq_pkg::in_word_t
//   out      output     out_valid/out_stall  ptq_pkg::out_word_t
//   cfg      input      cfg_we               cfg_data (paused)
//
// One word is processed at a time. For an add, the shift behind the insertion point
// moves one entry per cycle. Reset is synchronous; the entry memory is not cleared.
// A stalled result holds in the output register and the next word waits until it
// is taken.
`timescale 1ns / 1ps
module priority_task_queue_top #(
  parameter int DEPTH = ptq_pkg::DEPTH_DEF,
  parameter int PRIO_LEVELS = ptq_pkg::PRIO_LEVELS_DEF,
  parameter int ID_BITS = ptq_pkg::ID_BITS_DEF
) (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_stall,
  input ptq_pkg::in_word_t in_data,
  output logic out_valid,
  input logic out_stall,
  output ptq_pkg::out_word_t out_data,
  input logic cfg_we,
  input logic cfg_data
);
  import ptq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = $clog2(PRIO_LEVELS);
  localparam logic [ID_BITS-1:0] ID_MAX = '1;

  typedef struct packed {
    logic [PW-1:0] prio;
    logic [ID_BITS-1:0] id;
    logic [31:0] routine;
    logic [31:0] argument;
    logic cancelled;
  } entry_t;

  entry_t mem [DEPTH];
  entry_t rd;
  logic [AW-1:0] raddr;
  logic re;
  logic we;
  logic [AW-1:0] waddr;
  entry_t wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd <= mem[raddr];
    end
  end

  state_t state, state_next;
  in_word_t cmd;
  logic [PW-1:0] prio_sat;
  logic [CW-1:0] idx, idx_next;
  logic rd_ok, rd_ok_next;
  logic [CW-1:0] count, count_next;
  logic [ID_BITS-1:0] next_id, next_id_next;
  logic [15:0] active, active_next;
  logic [15:0] done, done_next;
  logic paused;
  out_word_t res, res_next;
  logic ovalid, ovalid_next;
  logic [2:0] st, st_next;
  logic [15:0] rid, rid_next;
  logic [31:0] orout, orout_next, oarg, oarg_next;
  logic [CW-1:0] pos, pos_next;

  assign in_stall = (state != S_IDLE) || ovalid;
  assign out_valid = ovalid;
  assign out_data = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      next_id <= ID_BITS'(1);
      active <= '0;
      done <= '0;
      paused <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      next_id <= next_id_next;
      active <= active_next;
      done <= done_next;
      ovalid <= ovalid_next;
      if (cfg_we) begin
        paused <= cfg_data;
      end
    end
    if (state == S_IDLE && in_valid && !in_stall) begin
      cmd <= in_data;
    end
    idx <= idx_next;
    rd_ok <= rd_ok_next;
    pos <= pos_next;
    st <= st_next;
    rid <= rid_next;
    orout <= orout_next;
    oarg <= oarg_next;
    res <= res_next;
  end

  always_comb begin
    if (32'(cmd.priority_req) >= PRIO_LEVELS) begin
      prio_sat = PW'(PRIO_LEVELS - 1);
    end else begin
      prio_sat = PW'(cmd.priority_req);
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    next_id_next = next_id;
    active_next = active;
    done_next = done;
    ovalid_next = ovalid && out_stall;
    res_next = res;
    idx_next = idx;
    rd_ok_next = 1'b0;
    pos_next = pos;
    st_next = st;
    rid_next = rid;
    orout_next = orout;
    oarg_next = oarg;
    re = 1'b0;
    raddr = '0;
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          state_next = S_SCAN;
          idx_next = '0;
          st_next = ST_OK;
          rid_next = '0;
          orout_next = '0;
          oarg_next = '0;
          pos_next = count;
        end
      end
      S_SCAN: begin
        // idx is the next address to read; rd_ok marks rd as entry idx-1.
        priority case (cmd.func)
          FN_ADD: begin
            if (cmd.routine == '0) begin
              st_next = ST_BAD;
              state_next = S_DONE;
            end else if (count == CW'(DEPTH)) begin
              st_next = ST_FULL;
              state_next = S_DONE;
            end else if (rd_ok && rd.prio < prio_sat) begin
              pos_next = idx - CW'(1);
              idx_next = count;
              state_next = S_SHIFT;
            end else if (idx < count) begin
              re = 1'b1;
              raddr = AW'(idx);
              rd_ok_next = 1'b1;
              idx_next = idx + CW'(1);
            end else begin
              pos_next = count;
              idx_next = count;
              state_next = S_SHIFT;
            end
          end
          FN_CANCEL: begin
            if (cmd.task_id == '0) begin
              st_next = ST_NOTFOUND;
              state_next = S_DONE;
            end else if (rd_ok && 16'(rd.id) == cmd.task_id) begin
              we = 1'b1;
              waddr = AW'(idx - CW'(1));
              wdata = rd;
              wdata.cancelled = 1'b1;
              state_next = S_DONE;
            end else if (idx < count) begin
              re = 1'b1;
              raddr = AW'(idx);
              rd_ok_next = 1'b1;
              idx_next = idx + CW'(1);
            end else begin
              st_next = ST_NOTFOUND;
              state_next = S_DONE;
            end
          end
          FN_TAKE: begin
            if (paused) begin
              st_next = ST_PAUSED;
              state_next = S_DONE;
            end else if (count == '0) begin
              st_next = ST_EMPTY;
              state_next = S_DONE;
            end else if (!rd_ok && idx == '0) begin
              re = 1'b1;
              raddr = '0;
              rd_ok_next = 1'b1;
              idx_next = CW'(1);
            end else if (idx == CW'(1) && rd_ok) begin
              if (rd.cancelled) begin
                st_next = ST_DROPPED;
              end else begin
                rid_next = 16'(rd.id);
                orout_next = rd.routine;
                oarg_next = rd.argument;
                if (active != CNT_MAX) begin
                  active_next = active + 16'd1;
                end
              end
              idx_next = CW'(1);
              if (count > CW'(1)) begin
                re = 1'b1;
                raddr = AW'(1);
                rd_ok_next = 1'b1;
                idx_next = CW'(2);
              end
            end else if (rd_ok) begin
              // Move entry idx-1 down by one slot.
              we = 1'b1;
              waddr = AW'(idx - CW'(2));
              wdata = rd;
              if (idx < count) begin
                re = 1'b1;
                raddr = AW'(idx);
                rd_ok_next = 1'b1;
                idx_next = idx + CW'(1);
              end
            end else begin
              count_next = count - CW'(1);
              state_next = S_DONE;
            end
          end
          FN_FINISH: begin
            if (active != '0) begin
              active_next = active - 16'd1;
            end
            if (done != CNT_MAX) begin
              done_next = done + 16'd1;
            end
            state_next = S_DONE;
          end
          FN_CLEAR: begin
            done_next = '0;
            state_next = S_DONE;
          end
          default: begin
            st_next = ST_BAD;
            state_next = S_DONE;
          end
        endcase
      end
      S_SHIFT: begin
        // idx counts down from count to pos, moving entry idx-1 to idx.
        if (rd_ok) begin
          we = 1'b1;
          waddr = AW'(idx);
          wdata = rd;
          idx_next = idx - CW'(1);
          if (idx - CW'(1) > pos) begin
            re = 1'b1;
            raddr = AW'(idx - CW'(2));
            rd_ok_next = 1'b1;
          end else begin
            state_next = S_WRITE;
          end
        end else if (idx > pos) begin
          re = 1'b1;
          raddr = AW'(idx - CW'(1));
          rd_ok_next = 1'b1;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        we = 1'b1;
        waddr = AW'(pos);
        wdata.prio = prio_sat;
        wdata.id = next_id;
        wdata.routine = cmd.routine;
        wdata.argument = cmd.argument;
        wdata.cancelled = 1'b0;
        count_next = count + CW'(1);
        rid_next = 16'(next_id);
        next_id_next = (next_id == ID_MAX) ? ID_BITS'(1) : next_id + ID_BITS'(1);
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!ovalid) begin
          res_next.status = st;
          res_next.result_id = rid;
          res_next.out_routine = orout;
          res_next.out_argument = oarg;
          res_next.pending = 5'(count);
          res_next.active = active;
          res_next.completed = done;
          ovalid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
